[design/spq_pkg.sv]
// spq_pkg: shared constants, codes and types of the sorted priority queue
// depends on nothing; imported by every module of the block
package spq_pkg;

    localparam int CAPACITY   = 16;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int DATA_W     = 32;
    localparam int OUT_CNT_W  = 5;

    localparam logic       REQ_INSERT = 1'b0;
    localparam logic       REQ_REMOVE = 1'b1;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

[design/spq_ctrl.sv]
// spq_ctrl: request sequencer of the sorted priority queue
// depends on spq_pkg; drives capture and commit commands of spq_datapath
module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  spq_pkg::t_dp_sts i_sts,
    output spq_pkg::t_dp_cmd o_cmd
);
    import spq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.commit  = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

[design/spq_datapath.sv]
// spq_datapath: request register, row of compare-and-shift cells, fill count
// and result register; depends on spq_pkg, steered by spq_ctrl
module spq_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spq_pkg::t_dp_cmd            i_cmd,
    output spq_pkg::t_dp_sts            o_sts,
    input  logic                        i_req_type,
    input  logic signed [31:0]          i_value,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [1:0]                  o_status,
    output logic signed [31:0]          o_removed_value,
    output logic signed [31:0]          o_head_value,
    output logic                        o_head_valid,
    output logic [4:0]                  o_entry_count,
    output logic                        o_is_full,
    output logic                        o_is_empty
);
    import spq_pkg::*;

    logic                     r_req_type;
    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] r_entry [CAPACITY];
    logic signed [DATA_W-1:0] n_entry [CAPACITY];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    logic [1:0]               n_status;
    logic signed [DATA_W-1:0] n_removed;
    logic [CAPACITY-1:0]      ge;
    logic                     cur_full;
    logic                     cur_empty;
    logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;

    assign cur_full  = (r_count == CNT_W'(CAPACITY));
    assign cur_empty = (r_count == '0);

    // cells holding a value that stays ahead of the new one
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            ge[k] = (CNT_W'(k) < r_count) && (r_entry[k] >= r_value);
        end
    end

    always_comb begin
        n_status  = STAT_DONE;
        n_removed = '0;
        n_count   = r_count;
        for (int k = 0; k < CAPACITY; k++) begin
            n_entry[k] = r_entry[k];
        end
        if (r_req_type == REQ_INSERT) begin
            if (cur_full) begin
                n_status = STAT_FULL;
            end else begin
                n_count = r_count + 1'b1;
                for (int k = 0; k < CAPACITY; k++) begin
                    if (ge[k]) begin
                        n_entry[k] = r_entry[k];
                    end else if (k == 0) begin
                        n_entry[k] = r_value;
                    end else if (ge[(k == 0) ? 0 : k - 1]) begin
                        n_entry[k] = r_value;
                    end else begin
                        n_entry[k] = r_entry[(k == 0) ? 0 : k - 1];
                    end
                end
            end
        end else begin
            if (cur_empty) begin
                n_status = STAT_EMPTY;
            end else begin
                n_count   = r_count - 1'b1;
                n_removed = r_entry[0];
                for (int k = 0; k < CAPACITY - 1; k++) begin
                    n_entry[k] = r_entry[k + 1];
                end
            end
        end
    end

    assign cnt_ext = {{OUT_CNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_value    <= i_value;
        end
        if (i_cmd.commit) begin
            for (int k = 0; k < CAPACITY; k++) begin
                r_entry[k] <= n_entry[k];
            end
            o_status        <= n_status;
            o_removed_value <= n_removed;
            o_head_value    <= (n_count != '0) ? n_entry[0] : '0;
            o_head_valid    <= (n_count != '0);
            o_entry_count   <= cnt_ext[OUT_CNT_W-1:0];
            o_is_full       <= (n_count == CNT_W'(CAPACITY));
            o_is_empty      <= (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;

endmodule

[design/sorted_priority_queue_unit.sv]
// sorted_priority_queue_unit: bounded descending-order queue of signed values
// sequence: an accepted item is captured in the request register, then one pass of the
//   compare-and-shift cell row commits it and registers its result; a new item is not
//   taken until after that commit, which waits while an earlier result is held downstream
// reset: clears the state machine, fill count and result valid; stored
//   values are not cleared
module sorted_priority_queue_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_removed_value,
    output logic signed [31:0] o_head_value,
    output logic               o_head_valid,
    output logic [4:0]         o_entry_count,
    output logic               o_is_full,
    output logic               o_is_empty
);
    import spq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    spq_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_req_type      (i_req_type),
        .i_value         (i_value),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_head_value    (o_head_value),
        .o_head_valid    (o_head_valid),
        .o_entry_count   (o_entry_count),
        .o_is_full       (o_is_full),
        .o_is_empty      (o_is_empty)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after item accepted");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_FULL) |-> (o_is_full && o_removed_value == '0))
        else $error("full rejection without full queue");

    a_empty_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_EMPTY) |-> (o_is_empty && !o_head_valid))
        else $error("empty rejection without empty queue");

    a_flags_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_head_valid == !o_is_empty && !(o_is_full && o_is_empty)))
        else $error("result flags disagree");

endmodule

[dv/tb_sorted_priority_queue_unit.sv]
// tb_sorted_priority_queue_unit: self-checking testbench of the sorted priority queue
// an in-file scoreboard class mirrors the sorted entries and checks every result in order
// depends on spq_pkg and sorted_priority_queue_unit
module tb_sorted_priority_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 1625;
    localparam int LONG_HOLD    = 250;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] removed;
        logic signed [DATA_W-1:0] head;
        logic                     head_valid;
        logic [OUT_CNT_W-1:0]     count;
        logic                     full;
        logic                     empty;
    } t_queue_status;

    class sorted_queue_mirror;
        logic signed [DATA_W-1:0] entries [CAPACITY];
        int                       fill;
        t_queue_status            pending[$];
        int                       errors;
        int                       inserts;
        int                       removes;
        int                       full_rejects;
        int                       empty_rejects;
        int                       peak_fill;

        function new();
            fill          = 0;
            errors        = 0;
            inserts       = 0;
            removes       = 0;
            full_rejects  = 0;
            empty_rejects = 0;
            peak_fill     = 0;
        endfunction

        function void note_request(logic req, logic signed [DATA_W-1:0] v);
            t_queue_status r;
            int            pos;
            r         = '0;
            r.status  = STAT_DONE;
            if (req == REQ_INSERT) begin
                if (fill >= CAPACITY) begin
                    r.status = STAT_FULL;
                    full_rejects++;
                end else begin
                    // new value goes behind every entry greater or equal
                    pos = fill;
                    while (pos > 0 && entries[pos-1] < v) begin
                        entries[pos] = entries[pos-1];
                        pos--;
                    end
                    entries[pos] = v;
                    fill++;
                    inserts++;
                end
            end else begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                    empty_rejects++;
                end else begin
                    r.removed = entries[0];
                    for (int k = 1; k < fill; k++) entries[k-1] = entries[k];
                    fill--;
                    removes++;
                end
            end
            if (fill > peak_fill) peak_fill = fill;
            r.head       = (fill > 0) ? entries[0] : '0;
            r.head_valid = (fill > 0);
            r.count      = OUT_CNT_W'(fill);
            r.full       = (fill >= CAPACITY);
            r.empty      = (fill == 0);
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(t_queue_status got);
            t_queue_status want;
            if (pending.size() == 0) begin
                $error("result with no request waiting");
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
            compare_field("removed_value", want.removed, got.removed);
            compare_field("head_value", want.head, got.head);
            compare_field("head_valid", DATA_W'(want.head_valid), DATA_W'(got.head_valid));
            compare_field("entry_count", DATA_W'(want.count), DATA_W'(got.count));
            compare_field("is_full", DATA_W'(want.full), DATA_W'(got.full));
            compare_field("is_empty", DATA_W'(want.empty), DATA_W'(got.empty));
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_req_type;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_removed_value;
    logic signed [DATA_W-1:0] o_head_value;
    logic                     o_head_valid;
    logic [OUT_CNT_W-1:0]     o_entry_count;
    logic                     o_is_full;
    logic                     o_is_empty;

    sorted_queue_mirror board;
    int                 burst_left;
    int                 items_sent;
    int                 cycle_count;
    bit                 hold_off_req;

    sorted_priority_queue_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_head_value    (o_head_value),
        .o_head_valid    (o_head_valid),
        .o_entry_count   (o_entry_count),
        .o_is_full       (o_is_full),
        .o_is_empty      (o_is_empty)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : cycle_counter
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_sorted_priority_queue_unit: errors");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3:    return int'($urandom_range(0, 7)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic req, input logic signed [DATA_W-1:0] val);
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(req, val);
        items_sent++;
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    initial begin : stall_pattern
        int mode;
        int left;
        int phase;
        mode        = 0;
        left        = 0;
        phase       = 0;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 100);
            end
            left--;
            phase++;
            case (mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 9) < 6);
                default: i_out_stall <= (phase % 3 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_response('{o_status, o_removed_value, o_head_value, o_head_valid,
                                   o_entry_count, o_is_full, o_is_empty});
        end
    end

    initial begin : stimulus
        logic req;
        int   seg_left;
        int   bias;
        board        = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_INSERT;
        i_value      = '0;
        hold_off_req = 1'b0;
        burst_left   = 1;
        items_sent   = 0;
        seg_left     = 0;
        bias         = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // remove on empty, extremes, ties, fill to full, insert on full, partial drain
        send_item(REQ_REMOVE, '0);
        send_item(REQ_INSERT, 32'h7fff_ffff);
        send_item(REQ_INSERT, 32'h8000_0000);
        send_item(REQ_INSERT, 0);
        send_item(REQ_INSERT, -1);
        send_item(REQ_INSERT, 0);
        send_item(REQ_INSERT, 32'h7fff_ffff);
        send_item(REQ_INSERT, 1);
        repeat (CAPACITY - 7) send_item(REQ_INSERT, pick_value());
        send_item(REQ_INSERT, pick_value());
        repeat (6) send_item(REQ_REMOVE, $urandom);

        hold_off_req = 1'b1;
        while (items_sent < 24 + RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                bias     = $urandom_range(0, 2);
                seg_left = $urandom_range(8, 60);
            end
            seg_left--;
            case (bias)
                0:       req = ($urandom_range(0, 99) < 85) ? REQ_INSERT : REQ_REMOVE;
                1:       req = ($urandom_range(0, 99) < 85) ? REQ_REMOVE : REQ_INSERT;
                default: req = ($urandom_range(0, 1) == 0) ? REQ_INSERT : REQ_REMOVE;
            endcase
            send_item(req, pick_value());
            if (items_sent == 900) hold_off_req = 1'b1;
        end
        if (i_in_valid) i_in_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d inserts, %0d removes, peak fill %0d",
                 items_sent, board.inserts, board.removes, board.peak_fill);
        $display("rejected %0d inserts on full and %0d removes on empty",
                 board.full_rejects, board.empty_rejects);
        if (board.errors == 0) begin
            $display("tb_sorted_priority_queue_unit: clean");
        end else begin
            $display("tb_sorted_priority_queue_unit: errors");
        end
        $finish;
    end
endmodule
